// File: rtl/wwfc_pkg.sv
package wwfc_pkg;

    // input word
    typedef struct packed {
        logic        mode;
        logic [23:0] desired_fuel;
        logic [14:0] engine_speed;
        logic        cranking;
    } in_word_t;

    // output word
    typedef struct packed {
        logic [23:0] commanded_fuel;
        logic [23:0] wall_film;
        logic        bypassed;
    } out_word_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // capture input word, start new item
        logic div_start;  // start a long division
        logic div_step;   // one restoring step
        logic div_sel_x;  // 1: division for x, 0: division for command
        logic exp_init;   // set up the series
        logic exp_mul;    // term * t
        logic exp_div;    // term / n by reciprocal multiply
        logic exp_acc;    // accumulate term
        logic sq_step;    // one squaring
        logic alpha_fin;  // round alpha, clamp beta
        logic num_mul;    // (1-alpha)*film
        logic num_fin;    // form numerator
        logic cmd_fin;    // saturate command
        logic film_mul;   // film products
        logic film_fin;   // new film, build result
        logic out_bypass; // result for bypass
        logic out_clear;  // result for clear
    } ctrl_t;

    // datapath to controller status
    typedef struct packed {
        logic is_clear;
        logic is_bypass;
        logic x_big;
        logic num_zero;
    } stat_t;

    localparam logic REG_TAU  = 1'b0;
    localparam logic REG_BETA = 1'b1;

    localparam int EXP_TERMS  = 14;
    localparam int SQUARINGS  = 4;
    localparam int XDIV_STEPS = 52;
    localparam int CDIV_STEPS = 41;

endpackage

// File: rtl/wwfc_if.sv
interface wwfc_in_if;
    wwfc_pkg::in_word_t data;
    logic valid;
    logic ready;
    modport source (output data, output valid, input ready);
    modport sink (input data, input valid, output ready);
endinterface

interface wwfc_out_if;
    wwfc_pkg::out_word_t data;
    logic valid;
    logic ready;
    modport source (output data, output valid, input ready);
    modport sink (input data, input valid, output ready);
endinterface

// File: rtl/wwfc_ctrl.sv
module wwfc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             res_valid,
    input  logic             res_taken,
    input  wwfc_pkg::stat_t  stat,
    output wwfc_pkg::ctrl_t  ctrl
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DECIDE = 5'd1;
    localparam logic [4:0] S_XDIV   = 5'd2;
    localparam logic [4:0] S_XCHK   = 5'd3;
    localparam logic [4:0] S_EMUL   = 5'd4;
    localparam logic [4:0] S_EDIV   = 5'd5;
    localparam logic [4:0] S_EACC   = 5'd6;
    localparam logic [4:0] S_SQ     = 5'd7;
    localparam logic [4:0] S_AFIN   = 5'd8;
    localparam logic [4:0] S_NMUL   = 5'd9;
    localparam logic [4:0] S_NFIN   = 5'd10;
    localparam logic [4:0] S_CDIV   = 5'd11;
    localparam logic [4:0] S_FMUL   = 5'd12;
    localparam logic [4:0] S_FFIN   = 5'd13;
    localparam logic [4:0] S_DONE   = 5'd14;
    localparam logic [4:0] S_CSTEP  = 5'd15;
    localparam logic [4:0] S_CFIN   = 5'd16;

    logic [4:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [3:0] term_reg, term_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            term_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            term_reg  <= term_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        term_next  = term_reg;
        ctrl       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.is_clear)
                begin
                    ctrl.out_clear = 1'b1;
                    state_next     = S_DONE;
                end
                else if (stat.is_bypass)
                begin
                    ctrl.out_bypass = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    ctrl.div_start = 1'b1;
                    ctrl.div_sel_x = 1'b1;
                    cnt_next       = 6'(wwfc_pkg::XDIV_STEPS - 1);
                    state_next     = S_XDIV;
                end
            end
            S_XDIV:
            begin
                ctrl.div_step  = 1'b1;
                ctrl.div_sel_x = 1'b1;
                if (cnt_reg == '0)
                    state_next = S_XCHK;
                else
                    cnt_next = cnt_reg - 6'd1;
            end
            S_XCHK:
            begin
                if (stat.x_big)
                begin
                    ctrl.alpha_fin = 1'b1;
                    state_next     = S_NMUL;
                end
                else
                begin
                    ctrl.exp_init = 1'b1;
                    term_next     = 4'd1;
                    state_next    = S_EMUL;
                end
            end
            S_EMUL:
            begin
                ctrl.exp_mul = 1'b1;
                state_next   = S_EDIV;
            end
            S_EDIV:
            begin
                ctrl.exp_div = 1'b1;
                state_next   = S_EACC;
            end
            S_EACC:
            begin
                ctrl.exp_acc = 1'b1;
                if (term_reg == 4'(wwfc_pkg::EXP_TERMS))
                begin
                    cnt_next   = 6'(wwfc_pkg::SQUARINGS - 1);
                    state_next = S_SQ;
                end
                else
                begin
                    term_next  = term_reg + 4'd1;
                    state_next = S_EMUL;
                end
            end
            S_SQ:
            begin
                ctrl.sq_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = S_AFIN;
                else
                    cnt_next = cnt_reg - 6'd1;
            end
            S_AFIN:
            begin
                ctrl.alpha_fin = 1'b1;
                state_next     = S_NMUL;
            end
            S_NMUL:
            begin
                ctrl.num_mul = 1'b1;
                state_next   = S_NFIN;
            end
            S_NFIN:
            begin
                ctrl.num_fin = 1'b1;
                state_next   = S_CDIV;
            end
            S_CDIV:
            begin
                if (stat.num_zero)
                begin
                    ctrl.cmd_fin = 1'b1;
                    state_next   = S_FMUL;
                end
                else
                begin
                    ctrl.div_start = 1'b1;
                    cnt_next       = 6'(wwfc_pkg::CDIV_STEPS - 1);
                    state_next     = S_CSTEP;
                end
            end
            S_CSTEP:
            begin
                ctrl.div_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = S_CFIN;
                else
                    cnt_next = cnt_reg - 6'd1;
            end
            S_CFIN:
            begin
                ctrl.cmd_fin = 1'b1;
                state_next   = S_FMUL;
            end
            S_FMUL:
            begin
                ctrl.film_mul = 1'b1;
                state_next    = S_FFIN;
            end
            S_FFIN:
            begin
                ctrl.film_fin = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (res_taken)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/wwfc_datapath.sv
module wwfc_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  wwfc_pkg::ctrl_t     ctrl,
    output wwfc_pkg::stat_t     stat,
    input  wwfc_pkg::in_word_t  in_word,
    input  logic [15:0]         tau,
    input  logic [15:0]         beta_cfg,
    output wwfc_pkg::out_word_t res
);

    wwfc_pkg::in_word_t in_reg;
    logic [23:0] film_reg;

    // shared restoring divider: quotient up to 52 bits, divisor up to 31 bits
    logic [51:0] quo_reg;
    logic [51:0] dvd_reg;
    logic [30:0] rem_reg;
    logic [30:0] dvs_reg;

    logic [31:0] t_reg;
    logic [32:0] term_reg;
    logic [36:0] pos_reg, neg_reg;
    logic [63:0] prod_reg;
    logic [64:0] rq_reg;
    logic [3:0]  n_reg;
    logic [32:0] e_reg;
    logic [16:0] alpha_reg;
    logic [15:0] beta_reg;
    logic [40:0] num_reg;
    logic [23:0] cmd_reg;
    logic [40:0] fa_reg, fb_reg;
    logic        numz_reg;

    logic [31:0] rem_shift;
    logic [32:0] rem_try;
    logic [30:0] rpm_tau;
    logic [31:0] recip_lo;
    logic [5:0]  recip_s;
    logic [32:0] term_new;
    logic [36:0] pos_upd, neg_upd;
    logic [36:0] e_diff;
    logic [63:0] sq;
    logic [40:0] pos_fuel;
    logic [40:0] sub_fuel;
    logic [41:0] next_sum;
    logic [16:0] alpha_rnd;
    logic [16:0] alpha_sat;
    logic [16:0] den;
    logic [23:0] film_new;

    assign rpm_tau   = 31'(in_reg.engine_speed) * 31'(tau);
    assign rem_shift = {rem_reg, dvd_reg[51]};
    assign rem_try   = {1'b0, rem_shift} - {2'b0, dvs_reg};
    assign sq        = 64'(e_reg[31:0]) * 64'(e_reg[31:0]);
    assign pos_fuel  = {1'b0, in_reg.desired_fuel, 16'd0};
    assign sub_fuel  = prod_reg[40:0];
    assign next_sum  = {1'b0, fa_reg} + {1'b0, fb_reg} + 42'd32768;
    assign alpha_rnd = 17'((e_reg + 33'd32768) >> 16);
    assign alpha_sat = (alpha_rnd > 17'd65535) ? 17'd65535 : alpha_rnd;
    assign den       = 17'h10000 - {1'b0, beta_reg};
    assign film_new  = (next_sum[41:16] > 26'hFFFFFF) ? 24'hFFFFFF : next_sum[39:16];

    // reciprocal of n: floor(v / n) = (v * (2^32 + recip_lo)) >> recip_s
    always_comb
    begin
        case (n_reg)
            4'd3:    recip_lo = 32'h5555_5556;
            4'd5:    recip_lo = 32'h9999_999A;
            4'd6:    recip_lo = 32'h5555_5556;
            4'd7:    recip_lo = 32'h2492_4925;
            4'd9:    recip_lo = 32'hC71C_71C8;
            4'd10:   recip_lo = 32'h9999_999A;
            4'd11:   recip_lo = 32'h745D_1746;
            4'd12:   recip_lo = 32'h5555_5556;
            4'd13:   recip_lo = 32'h3B13_B13C;
            4'd14:   recip_lo = 32'h2492_4925;
            default: recip_lo = 32'h0000_0000;
        endcase
    end

    always_comb
    begin
        case (n_reg) inside
            4'd2:           recip_s = 6'd33;
            [4'd3:4'd4]:    recip_s = 6'd34;
            [4'd5:4'd8]:    recip_s = 6'd35;
            [4'd9:4'd15]:   recip_s = 6'd36;
            default:        recip_s = 6'd32;
        endcase
    end

    // next series term and sums including it
    assign term_new = 33'(rq_reg >> recip_s);
    assign pos_upd  = n_reg[0] ? pos_reg : pos_reg + 37'(term_new);
    assign neg_upd  = n_reg[0] ? neg_reg + 37'(term_new) : neg_reg;
    assign e_diff   = (pos_upd > neg_upd) ? pos_upd - neg_upd : '0;

    assign stat.is_clear  = in_reg.mode;
    assign stat.is_bypass = in_reg.cranking || (tau < 16'd10)
                            || (in_reg.engine_speed < 15'd100);
    assign stat.x_big     = (quo_reg[51:32] >= 20'd12);
    assign stat.num_zero  = numz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            film_reg <= '0;
        else if (ctrl.out_clear)
            film_reg <= '0;
        else if (ctrl.film_fin)
            film_reg <= film_new;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            in_reg <= in_word;

        // divider
        if (ctrl.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            if (ctrl.div_sel_x)
            begin
                dvd_reg <= {3'd0, 17'd120000, 32'd0};
                dvs_reg <= rpm_tau;
            end
            else
            begin
                dvd_reg <= {num_reg + 41'(den >> 1), 11'd0};
                dvs_reg <= 31'(den);
            end
        end
        else if (ctrl.div_step)
        begin
            dvd_reg <= {dvd_reg[50:0], 1'b0};
            if (!rem_try[32])
            begin
                rem_reg <= rem_try[30:0];
                quo_reg <= {quo_reg[50:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[30:0];
                quo_reg <= {quo_reg[50:0], 1'b0};
            end
        end

        // exp series
        if (ctrl.exp_init)
        begin
            t_reg    <= quo_reg[35:4];
            term_reg <= 33'h1_0000_0000;
            pos_reg  <= 37'h1_0000_0000;
            neg_reg  <= '0;
            n_reg    <= 4'd1;
        end
        if (ctrl.exp_mul)
            prod_reg <= 64'(term_reg[31:0]) * 64'(t_reg)
                        + (term_reg[32] ? {t_reg, 32'd0} : 64'd0);
        if (ctrl.exp_div)
            rq_reg <= {1'b0, prod_reg[63:32], 32'd0}
                      + 65'(64'(prod_reg[63:32]) * 64'(recip_lo));
        if (ctrl.exp_acc)
        begin
            term_reg <= term_new;
            pos_reg  <= pos_upd;
            neg_reg  <= neg_upd;
            n_reg    <= n_reg + 4'd1;
            if (n_reg == 4'(wwfc_pkg::EXP_TERMS))
                e_reg <= (e_diff > 37'hFFFF_FFFF) ? 33'hFFFF_FFFF : e_diff[32:0];
        end
        if (ctrl.sq_step)
            e_reg <= 33'((65'(sq) + 65'h8000_0000) >> 32);

        // alpha and beta
        if (ctrl.alpha_fin)
        begin
            if (stat.x_big)
            begin
                alpha_reg <= '0;
                beta_reg  <= '0;
            end
            else
            begin
                alpha_reg <= alpha_sat;
                beta_reg  <= ({1'b0, beta_cfg} > alpha_sat) ? alpha_sat[15:0] : beta_cfg;
            end
        end

        if (ctrl.num_mul)
            prod_reg <= 64'(17'h10000 - alpha_reg) * 64'(film_reg);
        if (ctrl.num_fin)
        begin
            numz_reg <= (pos_fuel <= sub_fuel);
            num_reg  <= pos_fuel - sub_fuel;
        end
        if (ctrl.cmd_fin)
        begin
            if (numz_reg)
                cmd_reg <= '0;
            else
                cmd_reg <= (quo_reg[51:24] != '0) ? 24'hFFFFFF : quo_reg[23:0];
        end
        if (ctrl.film_mul)
        begin
            fa_reg <= 41'(alpha_reg) * 41'(film_reg);
            fb_reg <= 41'(beta_reg) * 41'(cmd_reg);
        end

        // result word
        if (ctrl.out_clear)
            res <= '{commanded_fuel: '0, wall_film: '0, bypassed: 1'b0};
        else if (ctrl.out_bypass)
            res <= '{commanded_fuel: in_reg.desired_fuel, wall_film: film_reg,
                     bypassed: 1'b1};
        else if (ctrl.film_fin)
            res <= '{commanded_fuel: cmd_reg, wall_film: film_new, bypassed: 1'b0};
    end

endmodule

// File: rtl/wall_wetting_fuel_compensator_core.sv
// X-tau wall-wetting compensator. One item at a time: clear and bypass words
// go straight from the decision to the result; a compensated word runs through
// the shared bit-serial divider (52 steps for the exp argument, 41 for the
// command) and the 14-term exp series, each term a multiply, divide and add. When
// the exp argument reaches 12 (alpha is zero) the series and squarings are
// skipped; when the command floors at zero its division is skipped. Registers:
// film time constant at 0x0, deposit fraction at 0x4, both 16 bits.
module wall_wetting_fuel_compensator_core (
    input  logic        clk,
    input  logic        rst_n,
    wwfc_in_if.sink     in_ch,
    wwfc_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] tau_reg;
    logic [15:0] beta_reg;
    wwfc_pkg::ctrl_t ctrl;
    wwfc_pkg::stat_t stat;
    logic res_valid;

    assign pready = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tau_reg  <= '0;
            beta_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                wwfc_pkg::REG_TAU:  tau_reg  <= pwdata[15:0];
                wwfc_pkg::REG_BETA: beta_reg <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            wwfc_pkg::REG_TAU:  prdata = {16'd0, tau_reg};
            wwfc_pkg::REG_BETA: prdata = {16'd0, beta_reg};
        endcase
    end

    assign out_ch.valid = res_valid;

    wwfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .res_valid (res_valid),
        .res_taken (out_ch.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    wwfc_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .stat     (stat),
        .in_word  (in_ch.data),
        .tau      (tau_reg),
        .beta_cfg (beta_reg),
        .res      (out_ch.data)
    );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [23:0] MAX24 = 24'hFFFFFF;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    wwfc_in_if in_ch ();
    wwfc_out_if out_ch ();

    wall_wetting_fuel_compensator_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // predictor state and settings
    logic [23:0] film_model;
    logic [15:0] tau_model;
    logic [15:0] beta_model;

    wwfc_pkg::in_word_t pending_words[$];
    wwfc_pkg::out_word_t expected_words[$];
    int error_count;
    int cycle_count;
    bit feed_hold;
    bit hold_sink;
    bit in_taken;
    int sink_hold_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic report(input string what);
        error_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // alpha in Q0.16 from rpm and tau
    function automatic logic [15:0] film_retention(input logic [14:0] rpm,
                                                   input logic [15:0] tau);
        logic [63:0] prod;
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] e;
        logic [127:0] wide;
        logic [63:0] a;
        prod = 64'(rpm) * 64'(tau);
        x = (64'd120000 << 32) / prod;
        if (x >= (64'd12 << 32))
            return 16'd0;
        t = x >> 4;
        term = 64'd1 << 32;
        pos = term;
        neg = 0;
        for (int n = 1; n <= 14; n++)
        begin
            wide = 128'(term) * 128'(t);
            term = 64'(wide >> 32) / 64'(n);
            if (n % 2 == 1)
                neg += term;
            else
                pos += term;
        end
        e = (pos > neg) ? pos - neg : 64'd0;
        if (e > 64'hFFFFFFFF)
            e = 64'hFFFFFFFF;
        for (int n = 0; n < 4; n++)
        begin
            wide = 128'(e) * 128'(e) + (128'd1 << 31);
            e = 64'(wide >> 32);
        end
        a = (e + 64'd32768) >> 16;
        if (a > 64'd65535)
            a = 64'd65535;
        return a[15:0];
    endfunction

    // compensated command and new film for one word
    function automatic wwfc_pkg::out_word_t compensate(input wwfc_pkg::in_word_t w);
        wwfc_pkg::out_word_t r;
        logic [15:0] alpha;
        logic [15:0] beta;
        logic [63:0] pos;
        logic [63:0] sub;
        logic [63:0] den;
        logic [63:0] cmd;
        logic [63:0] next;
        if (w.mode)
        begin
            film_model = 0;
            r = '0;
            return r;
        end
        if (w.cranking || tau_model < 16'd10 || w.engine_speed < 15'd100)
        begin
            r.commanded_fuel = w.desired_fuel;
            r.wall_film = film_model;
            r.bypassed = 1'b1;
            return r;
        end
        alpha = film_retention(w.engine_speed, tau_model);
        beta = (beta_model > alpha) ? alpha : beta_model;
        pos = 64'(w.desired_fuel) << 16;
        sub = (64'd65536 - 64'(alpha)) * 64'(film_model);
        if (pos <= sub)
            cmd = 0;
        else
        begin
            den = 64'd65536 - 64'(beta);
            cmd = (pos - sub + (den >> 1)) / den;
            if (cmd > 64'(MAX24))
                cmd = 64'(MAX24);
        end
        next = (64'(alpha) * 64'(film_model) + 64'(beta) * cmd + 64'd32768) >> 16;
        if (next > 64'(MAX24))
            next = 64'(MAX24);
        film_model = next[23:0];
        r.commanded_fuel = cmd[23:0];
        r.wall_film = film_model;
        r.bypassed = 1'b0;
        return r;
    endfunction

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // driver: offers words from the pending queue
    int feed_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            feed_gap <= 0;
        end
        else if (in_ch.valid && !in_taken)
        begin
            // hold the offered word until it is taken
        end
        else if (feed_gap > 0)
        begin
            in_ch.valid <= 1'b0;
            feed_gap <= feed_gap - 1;
        end
        else if (pending_words.size() > 0 && !feed_hold)
        begin
            in_ch.data <= pending_words.pop_front();
            in_ch.valid <= 1'b1;
            feed_gap <= gap_length();
        end
        else
            in_ch.valid <= 1'b0;
    end

    // predict on acceptance
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
            expected_words.push_back(compensate(in_ch.data));
    end

    // receiver stalls
    int sink_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            sink_gap <= 0;
        end
        else if (hold_sink)
            out_ch.ready <= 1'b0;
        else if (sink_gap > 0)
        begin
            out_ch.ready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            sink_gap <= gap_length();
        end
    end

    // monitor: compare each word with the oldest expectation
    always @(posedge clk)
    begin
        wwfc_pkg::out_word_t exp_w;
        wwfc_pkg::out_word_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (expected_words.size() == 0)
                report("result word with nothing expected");
            else
            begin
                exp_w = expected_words.pop_front();
                if (got.commanded_fuel !== exp_w.commanded_fuel)
                    report($sformatf("commanded_fuel %h, expected %h",
                        got.commanded_fuel, exp_w.commanded_fuel));
                if (got.wall_film !== exp_w.wall_film)
                    report($sformatf("wall_film %h, expected %h",
                        got.wall_film, exp_w.wall_film));
                if (got.bypassed !== exp_w.bypassed)
                    report($sformatf("bypassed %b, expected %b",
                        got.bypassed, exp_w.bypassed));
            end
        end
    end

    // long receiver hold while the sender keeps offering
    always @(negedge clk)
    begin
        if (sink_hold_cycles > 0)
        begin
            hold_sink <= 1'b1;
            sink_hold_cycles <= sink_hold_cycles - 1;
        end
        else
            hold_sink <= 1'b0;
    end

    task automatic reg_write(input logic index, input logic [15:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (index == wwfc_pkg::REG_TAU)
            tau_model = value;
        else
            beta_model = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || in_ch.valid || expected_words.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic wwfc_pkg::in_word_t make_word(input logic mode,
                                                     input logic [23:0] fuel,
                                                     input logic [14:0] rpm,
                                                     input logic crank);
        wwfc_pkg::in_word_t w;
        w.mode = mode;
        w.desired_fuel = fuel;
        w.engine_speed = rpm;
        w.cranking = crank;
        return w;
    endfunction

    // mostly realistic compensated events, some noise
    function automatic wwfc_pkg::in_word_t random_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return make_word(1'b1, 24'($urandom), 15'($urandom), 1'($urandom));
        if (roll < 10)
            return make_word(1'b0, 24'($urandom), 15'($urandom), 1'b1);
        if (roll < 20)
            return make_word(1'b0, 24'($urandom), 15'($urandom), 1'($urandom));
        if (roll < 25)
            return make_word(1'b0, 24'($urandom), 15'($urandom_range(0, 120)), 1'b0);
        return make_word(1'b0, 24'($urandom_range(0, 24'h1FFFFF)),
            15'($urandom_range(100, 8000)), 1'b0);
    endfunction

    initial
    begin
        logic [15:0] tau_set[6];
        logic [15:0] beta_set[6];
        error_count = 0;
        cycle_count = 0;
        film_model = 0;
        tau_model = 0;
        beta_model = 0;
        feed_hold = 1'b0;
        hold_sink = 1'b0;
        sink_hold_cycles = 0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: registers at reset, bypass by small tau
        pending_words.push_back(make_word(1'b0, 24'h123456, 15'd3000, 1'b0));
        pending_words.push_back(make_word(1'b1, MAX24, 15'h7FFF, 1'b1));
        drain();
        reg_write(wwfc_pkg::REG_TAU, 16'd9);
        reg_write(wwfc_pkg::REG_BETA, 16'd20000);
        pending_words.push_back(make_word(1'b0, 24'h010000, 15'd3000, 1'b0));
        drain();
        reg_write(wwfc_pkg::REG_TAU, 16'd200);
        pending_words.push_back(make_word(1'b0, 24'h030000, 15'd3000, 1'b0));
        pending_words.push_back(make_word(1'b0, 24'h030000, 15'd3000, 1'b0));
        pending_words.push_back(make_word(1'b0, 24'h030000, 15'd99, 1'b0));
        pending_words.push_back(make_word(1'b0, 24'h030000, 15'd100, 1'b0));
        pending_words.push_back(make_word(1'b0, 24'h030000, 15'd3000, 1'b1));
        pending_words.push_back(make_word(1'b0, 24'h000000, 15'd6000, 1'b0));
        pending_words.push_back(make_word(1'b0, MAX24, 15'h7FFF, 1'b0));
        pending_words.push_back(make_word(1'b0, MAX24, 15'h7FFF, 1'b0));
        pending_words.push_back(make_word(1'b0, 24'h000001, 15'd100, 1'b0));
        pending_words.push_back(make_word(1'b1, 24'h000000, 15'd0, 1'b0));
        drain();
        reg_write(wwfc_pkg::REG_TAU, 16'hFFFF);
        reg_write(wwfc_pkg::REG_BETA, 16'hFFFF);
        pending_words.push_back(make_word(1'b0, MAX24, 15'h7FFF, 1'b0));
        pending_words.push_back(make_word(1'b0, MAX24, 15'd100, 1'b0));
        pending_words.push_back(make_word(1'b0, 24'h000010, 15'd100, 1'b0));
        pending_words.push_back(make_word(1'b0, MAX24, 15'd5000, 1'b0));
        drain();
        reg_write(wwfc_pkg::REG_TAU, 16'd10);
        reg_write(wwfc_pkg::REG_BETA, 16'd0);
        pending_words.push_back(make_word(1'b0, 24'h050000, 15'd100, 1'b0));
        pending_words.push_back(make_word(1'b0, 24'h050000, 15'h7FFF, 1'b0));
        drain();

        // random phases across settings
        tau_set = '{16'd10, 16'd50, 16'd300, 16'd2000, 16'hFFFF, 16'd9};
        beta_set = '{16'd0, 16'd8000, 16'd30000, 16'd65535, 16'd1, 16'd40000};
        for (int p = 0; p < 6; p++)
        begin
            reg_write(wwfc_pkg::REG_TAU, (p < 5 && $urandom_range(0, 1)) ?
                16'($urandom_range(10, 5000)) : tau_set[p]);
            reg_write(wwfc_pkg::REG_BETA, (p == 2) ? 16'($urandom) : beta_set[p]);
            if (p == 1)
                sink_hold_cycles = 3000;
            for (int i = 0; i < 145; i++)
            begin
                pending_words.push_back(random_word());
                if (i == 70)
                begin
                    // sender waits until every result has come back
                    while (pending_words.size() > 0 || in_ch.valid)
                        @(posedge clk);
                    feed_hold = 1'b1;
                    while (expected_words.size() > 0)
                        @(posedge clk);
                    feed_hold = 1'b0;
                end
            end
            drain();
        end

        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// File: wall_wetting_fuel_compensator_core.f
rtl/wwfc_pkg.sv
rtl/wwfc_if.sv
rtl/wwfc_ctrl.sv
rtl/wwfc_datapath.sv
rtl/wall_wetting_fuel_compensator_core.sv
tb/testbench.sv
